// ===== design/md5_pkg.sv =====
// Shared types, constants and lookup functions for the MD5 engine.
`default_nettype none
package md5_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int NWORDS  = 16;
    localparam int POS_W   = 6;
    localparam int WIDX_W  = 4;
    localparam int STEP_W  = 6;
    localparam int TOTAL_W = 61;
    localparam int LEN_W   = 64;

    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
    localparam logic [POS_W-1:0]  LEN_POS  = 6'd56;
    localparam logic [POS_W-1:0]  LAST_POS = 6'd63;

    // Byte write into the block buffer
    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_buf_wr;

    // Sine-derived additive constant for each step
    function automatic logic [WORD_W-1:0] md5_sine(input logic [STEP_W-1:0] step);
        logic [WORD_W-1:0] k;
        case (step)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Left-rotate amount, chosen by round and step within a group of four
    function automatic logic [4:0] md5_rot(input logic [STEP_W-1:0] step);
        logic [4:0] s;
        case ({step[5:4], step[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word schedule, all arithmetic modulo 16
    function automatic logic [WIDX_W-1:0] md5_word_idx(input logic [STEP_W-1:0] step);
        logic [WIDX_W-1:0] s;
        logic [WIDX_W-1:0] idx;
        s = step[3:0];
        case (step[5:4])
            2'd0:    idx = s;
            2'd1:    idx = s + (s << 2) + 4'd1;
            2'd2:    idx = s + (s << 1) + 4'd5;
            2'd3:    idx = (s << 3) - s;
            default: idx = s;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== design/md5_stream_if.sv =====
// Valid/ready channel interfaces for message input and digest output.
`default_nettype none
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface
`default_nettype wire

// ===== design/md5_blkbuf.sv =====
// Sixteen-word block buffer: byte-lane writes, one registered word read.
`default_nettype none
module md5_blkbuf (
    input  wire logic                                i_clk,
    input  wire md5_pkg::t_buf_wr                    i_wr,
    input  wire logic [md5_pkg::WIDX_W-1:0]          i_rd_idx,
    output logic      [md5_pkg::WORD_W-1:0]          o_rd_word
);

    logic [md5_pkg::WORD_W-1:0] r_mem [md5_pkg::NWORDS];
    logic [md5_pkg::WORD_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.pos[5:2]][8*i_wr.pos[1:0] +: 8] <= i_wr.data;
        end
        r_rd_word <= r_mem[i_rd_idx];
    end

    assign o_rd_word = r_rd_word;

endmodule
`default_nettype wire

// ===== design/md5_round.sv =====
// One MD5 step: round function, additive constant, rotation and final add.
`default_nettype none
module md5_round (
    input  wire logic [md5_pkg::WORD_W-1:0] i_a,
    input  wire logic [md5_pkg::WORD_W-1:0] i_b,
    input  wire logic [md5_pkg::WORD_W-1:0] i_c,
    input  wire logic [md5_pkg::WORD_W-1:0] i_d,
    input  wire logic [md5_pkg::STEP_W-1:0] i_step,
    input  wire logic [md5_pkg::WORD_W-1:0] i_w,
    output logic      [md5_pkg::WORD_W-1:0] o_t
);

    logic [md5_pkg::WORD_W-1:0] f;
    logic [md5_pkg::WORD_W-1:0] sum;
    logic [md5_pkg::WORD_W-1:0] rot;
    logic [4:0]                 sh;

    always_comb begin
        case (i_step[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_b & i_d) | (i_c & ~i_d);
            2'd2:    f = i_b ^ i_c ^ i_d;
            2'd3:    f = i_c ^ (i_b | ~i_d);
            default: f = '0;
        endcase
    end

    assign sum = i_a + f + md5_pkg::md5_sine(i_step) + i_w;
    assign sh  = md5_pkg::md5_rot(i_step);
    // every rotate amount is non-zero, so the right shift stays below 32
    assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    assign o_t = i_b + rot;

endmodule
`default_nettype wire

// ===== design/md5_hash_engine_core.sv =====
// Top level of the MD5 engine: byte intake, padding and step sequencer.
//
//  channel | dir | payload                               | transaction
//  i_in    | in  | kind, data_byte                       | one byte or finish
//  o_out   | out | digest_word, word_index, last_word    | one chain word
//
// The input takes a byte while idle; every 64th byte starts a block run of
// the steps on one shared step unit, followed by the chain add. A finish walks
// the padding one byte a cycle, with one or two block runs, and then offers
// the four words. Reset (synchronous, active low) loads the initial chain
// value and clears the counters; the block buffer is not cleared. The input
// is held off while padding, running steps, adding the chain or offering the
// digest; a stalled output holds.
`default_nettype none
module md5_hash_engine_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    md5_in_if.sink    i_in,
    md5_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                          r_state;
    logic [md5_pkg::STEP_W-1:0]          r_step;
    logic [md5_pkg::WORD_W-1:0]          r_a, r_b, r_c, r_d;
    logic [md5_pkg::WORD_W-1:0]          r_chain [4];
    logic [md5_pkg::POS_W-1:0]           r_fill;
    logic [md5_pkg::TOTAL_W-1:0]         r_total;
    logic                                r_pad_first;  // marker byte still to go
    logic                                r_len_ok;     // length may go in this block
    logic                                r_finish;     // message finished; padding or digest still to go
    logic                                r_last_blk;   // running block is the final one
    logic [1:0]                          r_emit_idx;

    md5_pkg::t_buf_wr                    buf_wr;
    logic [md5_pkg::WIDX_W-1:0]          rd_idx;
    logic [md5_pkg::WORD_W-1:0]          rd_word;
    logic [md5_pkg::WORD_W-1:0]          step_t;
    logic [md5_pkg::LEN_W-1:0]           bit_len;
    logic [md5_pkg::BYTE_W-1:0]          len_byte;
    logic                                in_fire;
    logic                                out_fire;
    logic                                push_len;
    logic [md5_pkg::STEP_W-1:0]          step_next;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // Length in bits, low byte first, taken from the running byte count
    assign bit_len  = {r_total, 3'b000};
    assign len_byte = bit_len[8*r_fill[2:0] +: 8];
    assign push_len = !r_pad_first && r_len_ok && (r_fill >= md5_pkg::LEN_POS);

    always_comb begin
        buf_wr.pos = r_fill;
        if (r_state == S_PAD) begin
            buf_wr.en = 1'b1;
            if (r_pad_first) begin
                buf_wr.data = md5_pkg::PAD_MARK;
            end else if (push_len) begin
                buf_wr.data = len_byte;
            end else begin
                buf_wr.data = '0;
            end
        end else begin
            buf_wr.en   = in_fire && !i_in.kind;
            buf_wr.data = i_in.data_byte;
        end
    end

    // Fetch one step ahead: the read is registered in the buffer
    assign step_next = r_step + 6'd1;
    assign rd_idx    = (r_state == S_RUN) ? md5_pkg::md5_word_idx(step_next)
                                          : md5_pkg::md5_word_idx('0);

    md5_blkbuf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_idx  (rd_idx),
        .o_rd_word (rd_word)
    );

    md5_round u_round (
        .i_a    (r_a),
        .i_b    (r_b),
        .i_c    (r_c),
        .i_d    (r_d),
        .i_step (r_step),
        .i_w    (rd_word),
        .o_t    (step_t)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_EMIT);
    assign o_out.digest_word = r_chain[r_emit_idx];
    assign o_out.word_index  = r_emit_idx;
    assign o_out.last_word   = (r_emit_idx == 2'd3);

    // Working variables: payload only, loaded at the start of each block
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= step_t;
        end else begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_chain[0]  <= md5_pkg::IV0;
            r_chain[1]  <= md5_pkg::IV1;
            r_chain[2]  <= md5_pkg::IV2;
            r_chain[3]  <= md5_pkg::IV3;
            r_fill      <= '0;
            r_total     <= '0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_finish    <= 1'b0;
            r_last_blk  <= 1'b0;
            r_emit_idx  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in.kind) begin
                            // start padding; the marker goes in next cycle
                            r_finish    <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_state     <= S_PAD;
                        end else begin
                            r_total <= r_total + 61'd1;
                            r_step  <= '0;
                            if (r_fill == md5_pkg::LAST_POS) begin
                                r_fill     <= '0;
                                r_last_blk <= 1'b0;
                                r_state    <= S_RUN;
                            end else begin
                                r_fill <= r_fill + 6'd1;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                    end
                    r_step <= '0;
                    if (r_fill == md5_pkg::LAST_POS) begin
                        // a block boundary: run it; a length not yet written fits in the next block
                        r_fill     <= '0;
                        r_last_blk <= push_len;
                        r_len_ok   <= 1'b1;
                        r_state    <= S_RUN;
                    end else begin
                        // the length fits here only if the marker left room
                        if (r_pad_first) begin
                            r_len_ok <= (r_fill < md5_pkg::LEN_POS);
                        end
                        r_fill <= r_fill + 6'd1;
                    end
                end
                S_RUN: begin
                    r_step <= step_next;
                    if (r_step == md5_pkg::LAST_POS) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_emit_idx <= '0;
                    if (r_finish && r_last_blk) begin
                        r_state <= S_EMIT;
                    end else if (r_finish) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_fire) begin
                        if (r_emit_idx == 2'd3) begin
                            // digest delivered: back to a fresh message
                            r_chain[0] <= md5_pkg::IV0;
                            r_chain[1] <= md5_pkg::IV1;
                            r_chain[2] <= md5_pkg::IV2;
                            r_chain[3] <= md5_pkg::IV3;
                            r_total    <= '0;
                            r_finish   <= 1'b0;
                            r_last_blk <= 1'b0;
                            r_len_ok   <= 1'b0;
                            r_emit_idx <= '0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_emit_idx <= r_emit_idx + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/md5_checker.sv =====
// Port-level checker for the MD5 engine, bound to the top level.
`default_nettype none
module md5_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_digest_word,
    input wire logic [1:0]  i_word_index,
    input wire logic        i_last_word
);

    // A stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_digest_word) && $stable(i_word_index))
        else $error("digest word changed while stalled");

    // Intake and digest delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while digest offered");

    // Words follow one another in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_word |=>
            i_out_valid && (i_word_index == $past(i_word_index) + 2'd1))
        else $error("digest word skipped or repeated");

    // The last word closes the digest and the input opens again
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_word |=> !i_out_valid && i_in_ready)
        else $error("digest continued after last word");

endmodule

bind md5_hash_engine_core md5_checker u_md5_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_digest_word (o_out.digest_word),
    .i_word_index  (o_out.word_index),
    .i_last_word   (o_out.last_word)
);
`default_nettype wire

// ===== dv/md5_digest_tracker_pkg.sv =====
// Message-digest tracker for the MD5 engine bench: running hash state and pending digest words.
package md5_digest_tracker_pkg;

    import md5_pkg::*;

    typedef enum logic {
        MSG_APPEND = 1'b0,
        MSG_FINISH = 1'b1
    } msg_kind_e;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] STEP_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int STEP_ROT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    class md5_digest_tracker;

        logic [31:0]  chain [4];
        logic [31:0]  block [16];
        logic [5:0]   fill;
        logic [60:0]  byte_count;
        digest_word_t digest_queue [$];
        int           failures;

        function new();
            failures = 0;
            foreach (block[i]) block[i] = '0;
            restart();
        endfunction

        function void restart();
            chain[0]   = IV0;
            chain[1]   = IV1;
            chain[2]   = IV2;
            chain[3]   = IV3;
            fill       = '0;
            byte_count = '0;
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t;
            int          w;
            int          rnd;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int step = 0; step < 64; step++) begin
                rnd = step / 16;
                case (rnd)
                    0: begin
                        f = (b & c) | (~b & d);
                        w = step % 16;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        w = (5 * step + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        w = (3 * step + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        w = (7 * step) % 16;
                    end
                endcase
                t = a + f + STEP_K[step] + block[w];
                t = (t << STEP_ROT[rnd * 4 + step % 4]) |
                    (t >> (32 - STEP_ROT[rnd * 4 + step % 4]));
                t = b + t;
                a = d;
                d = c;
                c = b;
                b = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void push_byte(logic [7:0] v);
            block[fill[5:2]][fill[1:0] * 8 +: 8] = v;
            if (fill == LAST_POS) begin
                compress();
                fill = '0;
            end else begin
                fill = fill + 6'd1;
            end
        endfunction

        function void absorb_item(msg_kind_e k, logic [7:0] data);
            logic [63:0]  bit_len;
            digest_word_t dw;
            if (k == MSG_APPEND) begin
                push_byte(data);
                byte_count = byte_count + 61'd1;
                return;
            end
            bit_len = {byte_count, 3'b000};
            push_byte(PAD_MARK);
            while (fill != LEN_POS) push_byte(8'h00);
            for (int n = 0; n < 8; n++) push_byte(bit_len[8 * n +: 8]);
            for (int n = 0; n < 4; n++) begin
                dw.word  = chain[n];
                dw.index = 2'(n);
                dw.last  = (n == 3);
                digest_queue.push_back(dw);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] index, logic last);
            digest_word_t dw;
            if (digest_queue.size() == 0) begin
                $error("digest_word %08h arrived with nothing pending", word);
                failures++;
                return;
            end
            dw = digest_queue.pop_front();
            if (word !== dw.word) begin
                $error("digest_word expected %08h actual %08h", dw.word, word);
                failures++;
            end
            if (index !== dw.index) begin
                $error("word_index expected %0d actual %0d", dw.index, index);
                failures++;
            end
            if (last !== dw.last) begin
                $error("last_word expected %0b actual %0b", dw.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return digest_queue.size();
        endfunction

    endclass

endpackage

// ===== dv/md5_hash_engine_core_tb.sv =====
// Self-checking bench for md5_hash_engine_core: byte streams in, digest words checked out.
module md5_hash_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import md5_pkg::*;
    import md5_digest_tracker_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_hash_engine_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    md5_digest_tracker tracker = new();

    int unsigned items_sent;
    int unsigned msgs_sent;
    int unsigned words_taken;

    always #5 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one transaction from the falling edge; hold it until accepted.
    task automatic send_item(msg_kind_e k, logic [7:0] data, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid     = 1'b0;
            in_ch.kind      = 1'($urandom_range(0, 1));
            in_ch.data_byte = 8'($urandom_range(0, 255));
        end
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.kind      = k;
        in_ch.data_byte = data;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.absorb_item(k, data);
        items_sent++;
    endtask

    // Send len random bytes and a finish; a steady message has no idle cycles.
    task automatic send_message(int len, bit steady);
        for (int n = 0; n < len; n++)
            send_item(MSG_APPEND, 8'($urandom_range(0, 255)), steady ? 0 : pick_gap());
        send_item(MSG_FINISH, 8'($urandom_range(0, 255)), steady ? 0 : pick_gap());
        msgs_sent++;
    endtask

    task automatic send_bytes_then_finish(logic [7:0] bytes [$]);
        foreach (bytes[n]) send_item(MSG_APPEND, bytes[n], pick_gap());
        send_item(MSG_FINISH, 8'hff, pick_gap());
        msgs_sent++;
    endtask

    // Digest receiver: random stalls, quiet stretches and one long hold-off
    // that holds the engine on its digest and so pushes back on the byte stream.
    initial begin
        int  stall;
        int  quiet;
        bit  held;
        stall = 0;
        quiet = 0;
        held  = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && words_taken >= 24) begin
                held = 1'b1;
                out_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else begin
                out_ch.ready = 1'b1;
                if (quiet > 0) begin
                    quiet--;
                end else begin
                    stall = pick_gap();
                    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(20, 80);
                end
            end
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                words_taken++;
            end
        end
    end

    // Main stimulus: directed messages first, then random ones.
    initial begin
        int r;
        int len;
        items_sent  = 0;
        msgs_sent   = 0;
        words_taken = 0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = MSG_APPEND;
        in_ch.data_byte = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty message: digest of the empty string straight after reset.
        send_item(MSG_FINISH, 8'h00, 0);
        msgs_sent++;
        // Byte extremes, the padding marker itself as data, and "abc".
        send_bytes_then_finish('{8'h00, 8'hff});
        send_bytes_then_finish('{8'h80});
        send_bytes_then_finish('{8'h61, 8'h62, 8'h63});
        // Alternating bit patterns, ending on a finished word boundary.
        send_bytes_then_finish('{8'h55, 8'haa, 8'h01, 8'hfe, 8'h7f, 8'h80,
                                 8'hf0, 8'h0f, 8'hff, 8'h00, 8'hc3, 8'h3c});
        // Two finishes in a row: empty message again after a digest.
        send_item(MSG_FINISH, 8'h5a, 0);
        msgs_sent++;

        // Random messages: many short, a good share around the one- and
        // two-block padding boundaries, a few of about two blocks in length.
        while (items_sent < 420 || msgs_sent < 16) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                len = $urandom_range(0, 20);
            end else if (r < 8) begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    default: len = $urandom_range(50, 70);
                endcase
            end else begin
                len = $urandom_range(110, 130);
            end
            send_message(len, $urandom_range(0, 3) == 0);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        // Drain the digests, then allow for a stray late word.
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/md5_pkg.sv
design/md5_stream_if.sv
design/md5_blkbuf.sv
design/md5_round.sv
design/md5_hash_engine_core.sv
design/md5_checker.sv
dv/md5_digest_tracker_pkg.sv
dv/md5_hash_engine_core_tb.sv
